// ----- design/c8_pkg.sv -----
// Package: word types, opcode constants, controller codes and font table for the CHIP-8 core.
`default_nettype none
package c8_pkg;

  localparam int ADDR_W        = 12;
  localparam int MEM_BYTES     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_W         = 5;
  localparam int FONT_BYTES    = 80;

  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam logic [11:0] PC_START  = 12'h200;
  localparam logic [11:0] ADDR_LAST = 12'hFFF;

  localparam logic [2:0] ACT_EXEC = 3'd0;
  localparam logic [2:0] ACT_TICK = 3'd1;
  localparam logic [2:0] ACT_LOAD = 3'd2;
  localparam logic [2:0] ACT_KEY  = 3'd3;
  localparam logic [2:0] ACT_ROW  = 3'd4;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEB  = 4'h3;
  localparam logic [3:0] OP_SNEB = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDB  = 4'h6;
  localparam logic [3:0] OP_ADDB = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;
  localparam logic [7:0] FX_GETDT = 8'h07;
  localparam logic [7:0] FX_SETDT = 8'h15;
  localparam logic [7:0] FX_SETST = 8'h18;
  localparam logic [7:0] FX_ADDI  = 8'h1E;
  localparam logic [7:0] FX_FONT  = 8'h29;
  localparam logic [7:0] FX_BCD   = 8'h33;
  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD  = 8'h65;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [3:0] FLAG_REG = 4'hF;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [3:0]  key_index;
    logic        key_down;
    logic [4:0]  row_index;
    logic [7:0]  random_byte;
  } in_word_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic        sound_active;
    logic [63:0] display_row;
  } out_word_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_FETCH_HI, S_FETCH_LO, S_READ_X, S_READ_Y, S_EXEC,
    S_DR_RD, S_DR_WR, S_DR_FLAG, S_RND, S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_DISPATCH, CMD_FETCH_HI, CMD_FETCH_LO, CMD_READ_X, CMD_READ_Y,
    CMD_EXEC, CMD_DR_RD, CMD_DR_WR, CMD_DR_FLAG, CMD_RND, CMD_BCD, CMD_ST_RD, CMD_ST_WR,
    CMD_LD_RD, CMD_LD_WR, CMD_DONE
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic capture;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] op;
    logic [7:0] lo;
    logic       clear_done;
    logic       cnt_is_x;
    logic       dr_done;
    logic       rnd_last;
    logic       bcd_last;
  } dp_status_t;

  localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [11:0] off;
    off = a - FONT_BASE;
    if (a >= FONT_BASE && off < 12'(FONT_BYTES)) return GLYPHS[off[6:0]];
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

// ----- design/c8_ctrl.sv -----
// Controller: sequencing state machine for the CHIP-8 core.
`default_nettype none
module c8_ctrl
  import c8_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire        out_stall,
  input  dp_status_t status,
  output ctrl_t      ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (status.clear_done) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: state_next = (status.action == ACT_EXEC) ? S_FETCH_HI : S_DONE;
      S_FETCH_HI: state_next = S_FETCH_LO;
      S_FETCH_LO: state_next = S_READ_X;
      S_READ_X:   state_next = S_READ_Y;
      S_READ_Y:   state_next = S_EXEC;
      S_EXEC: begin
        case (status.op)
          OP_DRW:  state_next = S_DR_RD;
          OP_RND:  state_next = (status.lo != 8'h00) ? S_RND : S_DONE;
          OP_MISC: begin
            case (status.lo)
              FX_BCD:   state_next = S_BCD;
              FX_STORE: state_next = S_ST_RD;
              FX_LOAD:  state_next = S_LD_RD;
              default:  state_next = S_DONE;
            endcase
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DR_RD:   state_next = status.dr_done ? S_DR_FLAG : S_DR_WR;
      S_DR_WR:   state_next = S_DR_RD;
      S_DR_FLAG: state_next = S_DONE;
      S_RND:     if (status.rnd_last) state_next = S_DONE;
      S_BCD:     if (status.bcd_last) state_next = S_DONE;
      S_ST_RD:   state_next = S_ST_WR;
      S_ST_WR:   state_next = status.cnt_is_x ? S_DONE : S_ST_RD;
      S_LD_RD:   state_next = S_LD_WR;
      S_LD_WR:   state_next = status.cnt_is_x ? S_DONE : S_LD_RD;
      S_DONE:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall      = (state != S_IDLE);
    ctrl.capture  = (state == S_IDLE) && in_valid;
    ctrl.load_out = (state == S_DONE) && (!out_valid || !out_stall);
    case (state)
      S_CLEAR:    ctrl.cmd = CMD_CLEAR;
      S_DISPATCH: ctrl.cmd = CMD_DISPATCH;
      S_FETCH_HI: ctrl.cmd = CMD_FETCH_HI;
      S_FETCH_LO: ctrl.cmd = CMD_FETCH_LO;
      S_READ_X:   ctrl.cmd = CMD_READ_X;
      S_READ_Y:   ctrl.cmd = CMD_READ_Y;
      S_EXEC:     ctrl.cmd = CMD_EXEC;
      S_DR_RD:    ctrl.cmd = CMD_DR_RD;
      S_DR_WR:    ctrl.cmd = CMD_DR_WR;
      S_DR_FLAG:  ctrl.cmd = CMD_DR_FLAG;
      S_RND:      ctrl.cmd = CMD_RND;
      S_BCD:      ctrl.cmd = CMD_BCD;
      S_ST_RD:    ctrl.cmd = CMD_ST_RD;
      S_ST_WR:    ctrl.cmd = CMD_ST_WR;
      S_LD_RD:    ctrl.cmd = CMD_LD_RD;
      S_LD_WR:    ctrl.cmd = CMD_LD_WR;
      S_DONE:     ctrl.cmd = CMD_DONE;
      default:    ctrl.cmd = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/c8_dp.sv -----
// Datapath: memories, register file, stack, timers, frame buffer and result register.
`default_nettype none
module c8_dp
  import c8_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  ctrl_t      ctrl,
  input  in_word_t   in_word,
  output out_word_t  out_word,
  output dp_status_t status
);

  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

  logic [7:0]  mem [MEM_BYTES];
  logic [63:0] fb  [SCREEN_HEIGHT];

  in_word_t    in_q;
  out_word_t   out_q;
  logic [7:0]  hi, lo, vx, vy_r, vq, mem_q, rem, delay, sound;
  logic [63:0] fb_q;
  logic        fbq_valid, hit;
  logic [SCREEN_HEIGHT-1:0] fb_valid;
  logic [11:0] pc, cnt;
  logic [15:0] ir;
  logic [SP_W-1:0] sp;
  logic [11:0] stack [STACK_DEPTH];
  logic [7:0]  v [16];
  logic [15:0] keys;

  logic [3:0]  x, y, n, op;
  logic [11:0] nnn, pc_inc, pc_skip, ir_addr, mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wd;
  logic [SP_W-1:0] sp_inc, sp_dec;
  logic [4:0]  fb_addr;
  logic [63:0] fb_row, sprite_mask;
  logic [8:0]  sum9, rnd_t, rnd_r;
  logic [7:0]  bcd_h, bcd_r, bcd_t, bcd_o, bcd_d;
  logic [15:0] bcd_mul;
  logic [3:0]  vaddr;

  assign op      = hi[7:4];
  assign x       = hi[3:0];
  assign y       = lo[7:4];
  assign n       = lo[3:0];
  assign nnn     = {hi[3:0], lo};
  assign pc_inc  = pc + 12'd2;
  assign pc_skip = pc + 12'd4;
  assign ir_addr = ir[11:0] + cnt;
  assign sp_inc  = (sp == SP_LAST) ? '0 : sp + 1'b1;
  assign sp_dec  = (sp == '0) ? SP_LAST : sp - 1'b1;
  assign sum9    = {1'b0, vx} + {1'b0, vq};

  assign fb_row      = fbq_valid ? fb_q : 64'd0;
  assign sprite_mask = ({mem_q, 56'd0} >> vx[5:0]) | ({mem_q, 56'd0} << (7'd64 - {1'b0, vx[5:0]}));

  assign rnd_t = {rem, in_q.random_byte[3'd7 - cnt[2:0]]};
  assign rnd_r = (rnd_t >= {1'b0, lo}) ? rnd_t - {1'b0, lo} : rnd_t;

  always_comb begin
    bcd_h   = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
    bcd_r   = vx - 8'(bcd_h * 8'd100);
    bcd_mul = {8'd0, bcd_r} * 16'd205;
    bcd_t   = {3'd0, bcd_mul[15:11]};
    bcd_o   = bcd_r - 8'(bcd_t * 8'd10);
    case (cnt[1:0])
      2'd0:    bcd_d = bcd_h;
      2'd1:    bcd_d = bcd_t;
      default: bcd_d = bcd_o;
    endcase
  end

  always_comb begin
    mem_addr = pc;
    mem_we   = 1'b0;
    mem_wd   = 8'd0;
    case (ctrl.cmd)
      CMD_CLEAR: begin
        mem_addr = cnt;
        mem_we   = 1'b1;
        mem_wd   = font_byte(cnt);
      end
      CMD_DISPATCH: begin
        mem_addr = in_q.load_address;
        mem_we   = (in_q.action == ACT_LOAD);
        mem_wd   = in_q.load_data;
      end
      CMD_FETCH_LO: mem_addr = pc + 12'd1;
      CMD_DR_RD, CMD_LD_RD: mem_addr = ir_addr;
      CMD_BCD: begin
        mem_addr = ir_addr;
        mem_we   = 1'b1;
        mem_wd   = bcd_d;
      end
      CMD_ST_WR: begin
        mem_addr = ir_addr;
        mem_we   = 1'b1;
        mem_wd   = vq;
      end
      default: mem_addr = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  assign fb_addr = (ctrl.cmd == CMD_DISPATCH) ? in_q.row_index : vy_r[4:0] + cnt[4:0];

  always_ff @(posedge clk) begin
    if (ctrl.cmd == CMD_DISPATCH || ctrl.cmd == CMD_DR_RD) fb_q <= fb[fb_addr];
    if (ctrl.cmd == CMD_DR_WR) fb[fb_addr] <= fb_row ^ sprite_mask;
  end

  always_comb begin
    case (ctrl.cmd)
      CMD_READ_X: vaddr = (hi[7:4] == OP_JPV0) ? 4'h0 : hi[3:0];
      CMD_READ_Y: vaddr = y;
      default:    vaddr = cnt[3:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_START;
      ir        <= 16'd0;
      sp        <= '0;
      delay     <= 8'd0;
      sound     <= 8'd0;
      keys      <= 16'd0;
      fb_valid  <= '0;
      fbq_valid <= 1'b0;
      cnt       <= 12'd0;
      for (int i = 0; i < 16; i++) v[i] <= 8'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= 12'd0;
    end else begin
      if (ctrl.cmd == CMD_DISPATCH || ctrl.cmd == CMD_DR_RD) fbq_valid <= fb_valid[fb_addr];
      if (ctrl.cmd == CMD_READ_X || ctrl.cmd == CMD_READ_Y || ctrl.cmd == CMD_ST_RD) begin
        vq <= v[vaddr];
      end
      case (ctrl.cmd)
        CMD_CLEAR: cnt <= cnt + 12'd1;
        CMD_DISPATCH: begin
          case (in_q.action)
            ACT_TICK: begin
              if (delay != 8'd0) delay <= delay - 8'd1;
              if (sound != 8'd0) sound <= sound - 8'd1;
            end
            ACT_KEY: keys[in_q.key_index] <= in_q.key_down;
            default: ;
          endcase
        end
        CMD_FETCH_LO: hi <= mem_q;
        CMD_READ_X:   lo <= mem_q;
        CMD_READ_Y:   vx <= vq;
        CMD_EXEC: begin
          vy_r <= vq;
          cnt  <= 12'd0;
          hit  <= 1'b0;
          rem  <= 8'd0;
          pc   <= pc_inc;
          case (op)
            OP_SYS: begin
              if (lo == SYS_CLS) fb_valid <= '0;
              else if (lo == SYS_RET) begin
                sp <= sp_dec;
                pc <= stack[sp_dec];
              end
            end
            OP_JP: pc <= nnn;
            OP_CALL: begin
              stack[sp] <= pc_inc;
              sp        <= sp_inc;
              pc        <= nnn;
            end
            OP_SEB:  if (vx == lo) pc <= pc_skip;
            OP_SNEB: if (vx != lo) pc <= pc_skip;
            OP_SER:  if (n == 4'h0 && vx == vq) pc <= pc_skip;
            OP_SNER: if (n == 4'h0 && vx != vq) pc <= pc_skip;
            OP_LDB:  v[x] <= lo;
            OP_ADDB: v[x] <= vx + lo;
            OP_ALU: begin
              case (n)
                ALU_MOV: v[x] <= vq;
                ALU_OR:  v[x] <= vx | vq;
                ALU_AND: v[x] <= vx & vq;
                ALU_XOR: v[x] <= vx ^ vq;
                ALU_ADD: begin
                  v[x] <= sum9[7:0];
                  v[FLAG_REG] <= {7'd0, sum9[8]};
                end
                ALU_SUB: begin
                  v[x] <= vx - vq;
                  v[FLAG_REG] <= {7'd0, vx >= vq};
                end
                ALU_SHR: begin
                  v[x] <= {1'b0, vq[7:1]};
                  v[FLAG_REG] <= {7'd0, vq[0]};
                end
                ALU_SBN: begin
                  v[x] <= vq - vx;
                  v[FLAG_REG] <= {7'd0, vq >= vx};
                end
                ALU_SHL: begin
                  v[x] <= {vq[6:0], 1'b0};
                  v[FLAG_REG] <= {7'd0, vq[7]};
                end
                default: ;
              endcase
            end
            OP_LDI:  ir <= {4'd0, nnn};
            OP_JPV0: pc <= nnn + {4'd0, vx};
            OP_KEY: begin
              if (lo == KEY_SKP && keys[vx[3:0]]) pc <= pc_skip;
              else if (lo == KEY_SKNP && !keys[vx[3:0]]) pc <= pc_skip;
            end
            OP_MISC: begin
              case (lo)
                FX_GETDT: v[x] <= delay;
                FX_SETDT: delay <= vx;
                FX_SETST: sound <= vx;
                FX_ADDI:  ir <= ir + {8'd0, vx};
                FX_FONT:  ir <= {4'd0, FONT_BASE} + {6'd0, vx, 2'd0} + {8'd0, vx};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        CMD_DR_WR: begin
          hit <= hit | (|(fb_row & sprite_mask));
          fb_valid[fb_addr] <= 1'b1;
          cnt <= cnt + 12'd1;
        end
        CMD_DR_FLAG: v[FLAG_REG] <= {7'd0, hit};
        CMD_RND: begin
          rem <= rnd_r[7:0];
          cnt <= cnt + 12'd1;
          if (cnt[2:0] == 3'd7) v[x] <= rnd_r[7:0];
        end
        CMD_BCD: cnt <= cnt + 12'd1;
        CMD_ST_WR: begin
          cnt <= cnt + 12'd1;
          if (cnt[3:0] == x) ir <= ir + {12'd0, x} + 16'd1;
        end
        CMD_LD_WR: begin
          v[cnt[3:0]] <= mem_q;
          cnt <= cnt + 12'd1;
          if (cnt[3:0] == x) ir <= ir + {12'd0, x} + 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) in_q <= in_word;
    if (ctrl.load_out) begin
      out_q.program_counter <= pc;
      out_q.sound_active    <= (sound != 8'd0);
      out_q.display_row     <= (in_q.action == ACT_ROW) ? fb_row : 64'd0;
    end
  end

  assign out_word = out_q;

  assign status.action     = in_q.action;
  assign status.op         = op;
  assign status.lo         = lo;
  assign status.clear_done = (cnt == ADDR_LAST);
  assign status.cnt_is_x   = (cnt[3:0] == x);
  assign status.dr_done    = (cnt[3:0] == n);
  assign status.rnd_last   = (cnt[2:0] == 3'd7);
  assign status.bcd_last   = (cnt[1:0] == 2'd2);

endmodule
`default_nettype wire

// ----- design/chip8_instruction_core.sv -----
// Top level: CHIP-8 processor core, controller plus datapath.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_word  (in_word_t)
//  output  | out_valid | out_stall | out_word (out_word_t)
//
// After reset a pass loads all of main memory (font at 0x050, zero elsewhere);
// no word is taken during it.
// Tick, load, key, read row and unused actions: dispatch, then done.
// Execute: fetch, read, exec; extra states for draw rows, FX55/FX65, RND and FX33.
// Memory and frame buffer have one port each, which sets the per-row draw cost.
// A new word is taken while the previous result waits in the output register.
`default_nettype none
module chip8_instruction_core
  import c8_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  wire       out_stall,
  output out_word_t out_word
);

  ctrl_t      ctrl;
  dp_status_t status;

  c8_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ctrl      (ctrl)
  );

  c8_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .in_word  (in_word),
    .out_word (out_word),
    .status   (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("core took a second word without finishing the first");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in progress");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cmd == CMD_CLEAR) |-> !out_valid)
    else $error("result presented during memory load pass");

endmodule
`default_nettype wire

// ----- tb/chip8_instruction_core_tb.sv -----
// Testbench for chip8_instruction_core: random programs checked against a scoreboard model.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_core_tb
  import c8_pkg::*;
;

  localparam int STALL_LIMIT = 20000;
  localparam int STACK_SIZE  = 16;

  class chip8_mirror;
    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  v [16];
    logic [15:0] idx;
    logic [11:0] pc;
    logic [11:0] stk [STACK_SIZE];
    int unsigned sp;
    logic [7:0]  dt;
    logic [7:0]  st;
    logic [63:0] fb [SCREEN_HEIGHT];
    bit          keys [16];
    out_word_t   expected_words [$];
    int          errors;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      for (int i = 0; i < FONT_BYTES; i++) mem[FONT_BASE + i] = GLYPHS[i];
      foreach (v[i]) v[i] = 8'h00;
      foreach (stk[i]) stk[i] = 12'h000;
      foreach (fb[i]) fb[i] = 64'h0;
      foreach (keys[i]) keys[i] = 1'b0;
      idx = 16'h0;
      pc = PC_START;
      sp = 0;
      dt = 8'h0;
      st = 8'h0;
      errors = 0;
    endfunction

    function void skip_if(bit c);
      if (c) pc = pc + 12'd2;
    endfunction

    function void alu_op(logic [3:0] x, logic [3:0] y, logic [3:0] n);
      logic [7:0] a, b;
      logic [8:0] sum;
      a = v[x];
      b = v[y];
      sum = {1'b0, a} + {1'b0, b};
      case (n)
        ALU_MOV: v[x] = b;
        ALU_OR:  v[x] = a | b;
        ALU_AND: v[x] = a & b;
        ALU_XOR: v[x] = a ^ b;
        ALU_ADD: begin v[x] = sum[7:0]; v[FLAG_REG] = {7'd0, sum[8]}; end
        ALU_SUB: begin v[x] = a - b; v[FLAG_REG] = {7'd0, a >= b}; end
        ALU_SHR: begin v[x] = b >> 1; v[FLAG_REG] = {7'd0, b[0]}; end
        ALU_SBN: begin v[x] = b - a; v[FLAG_REG] = {7'd0, b >= a}; end
        ALU_SHL: begin v[x] = b << 1; v[FLAG_REG] = {7'd0, b[7]}; end
        default: ;
      endcase
    endfunction

    function void sprite(logic [3:0] x, logic [3:0] y, logic [3:0] n);
      int unsigned x0, y0, py, px;
      logic [7:0] data;
      bit hit;
      x0 = v[x];
      y0 = v[y];
      hit = 0;
      for (int r = 0; r < n; r++) begin
        py = (y0 + r) % SCREEN_HEIGHT;
        data = mem[12'(idx + r)];
        for (int c = 0; c < 8; c++) begin
          px = (x0 + c) % SCREEN_WIDTH;
          if (data[7 - c]) begin
            if (fb[py][63 - px]) hit = 1;
            fb[py][63 - px] = ~fb[py][63 - px];
          end
        end
      end
      v[FLAG_REG] = {7'd0, hit};
    endfunction

    function void misc_op(logic [3:0] x, logic [7:0] lo);
      case (lo)
        FX_GETDT: v[x] = dt;
        FX_SETDT: dt = v[x];
        FX_SETST: st = v[x];
        FX_ADDI:  idx = idx + 16'(v[x]);
        FX_FONT:  idx = 16'(FONT_BASE) + 16'(v[x]) * 16'd5;
        FX_BCD: begin
          mem[12'(idx)]     = v[x] / 100;
          mem[12'(idx + 1)] = (v[x] % 100) / 10;
          mem[12'(idx + 2)] = v[x] % 10;
        end
        FX_STORE: begin
          for (int i = 0; i <= x; i++) mem[12'(idx + i)] = v[i];
          idx = idx + 16'(x) + 16'd1;
        end
        FX_LOAD: begin
          for (int i = 0; i <= x; i++) v[i] = mem[12'(idx + i)];
          idx = idx + 16'(x) + 16'd1;
        end
        default: ;
      endcase
    endfunction

    function void execute(logic [7:0] rnd);
      logic [7:0] hi, lo;
      logic [3:0] x, y, n;
      logic [11:0] nnn;
      hi = mem[pc];
      lo = mem[pc + 12'd1];
      x = hi[3:0];
      y = lo[7:4];
      n = lo[3:0];
      nnn = {x, lo};
      pc = pc + 12'd2;
      case (hi[7:4])
        OP_SYS: begin
          if (lo == SYS_CLS) begin
            foreach (fb[i]) fb[i] = 64'h0;
          end else if (lo == SYS_RET) begin
            sp = (sp == 0) ? STACK_SIZE - 1 : sp - 1;
            pc = stk[sp];
          end
        end
        OP_JP: pc = nnn;
        OP_CALL: begin
          stk[sp] = pc;
          sp = (sp + 1 >= STACK_SIZE) ? 0 : sp + 1;
          pc = nnn;
        end
        OP_SEB:  skip_if(v[x] == lo);
        OP_SNEB: skip_if(v[x] != lo);
        OP_SER:  if (n == 0) skip_if(v[x] == v[y]);
        OP_LDB:  v[x] = lo;
        OP_ADDB: v[x] = v[x] + lo;
        OP_ALU:  alu_op(x, y, n);
        OP_SNER: if (n == 0) skip_if(v[x] != v[y]);
        OP_LDI:  idx = {4'h0, nnn};
        OP_JPV0: pc = nnn + 12'(v[0]);
        OP_RND:  if (lo != 0) v[x] = rnd % lo;
        OP_DRW:  sprite(x, y, n);
        OP_KEY: begin
          if (lo == KEY_SKP) skip_if(keys[v[x][3:0]]);
          else if (lo == KEY_SKNP) skip_if(!keys[v[x][3:0]]);
        end
        default: misc_op(x, lo);
      endcase
    endfunction

    function void note_input(in_word_t w);
      out_word_t e;
      logic [63:0] row;
      row = 64'h0;
      case (w.action)
        ACT_EXEC: execute(w.random_byte);
        ACT_TICK: begin
          if (dt != 0) dt = dt - 8'd1;
          if (st != 0) st = st - 8'd1;
        end
        ACT_LOAD: mem[w.load_address] = w.load_data;
        ACT_KEY:  keys[w.key_index] = w.key_down;
        ACT_ROW:  row = fb[w.row_index];
        default: ;
      endcase
      e.program_counter = pc;
      e.sound_active = (st != 0);
      e.display_row = row;
      expected_words.push_back(e);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (got.program_counter !== e.program_counter) begin
        $display("%0t: program_counter expected %h actual %h", $time,
                 e.program_counter, got.program_counter);
        errors++;
      end
      if (got.sound_active !== e.sound_active) begin
        $display("%0t: sound_active expected %b actual %b", $time,
                 e.sound_active, got.sound_active);
        errors++;
      end
      if (got.display_row !== e.display_row) begin
        $display("%0t: display_row expected %h actual %h", $time,
                 e.display_row, got.display_row);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  chip8_mirror mirror;
  int idle_pct;
  int quiet_cycles;

  chip8_instruction_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) mirror.check_result(out_word);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("chip8_instruction_core_tb: done, errors");
        $finish;
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  function automatic in_word_t noise_word(logic [2:0] act);
    in_word_t w;
    w = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
    w.action = act;
    return w;
  endfunction

  task automatic send(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    mirror.note_input(w);
  endtask

  task automatic run_op(logic [15:0] op, bit place);
    in_word_t w;
    if (place) begin
      w = noise_word(ACT_LOAD);
      w.load_address = mirror.pc;
      w.load_data = op[15:8];
      send(w);
      w = noise_word(ACT_LOAD);
      w.load_address = mirror.pc + 12'd1;
      w.load_data = op[7:0];
      send(w);
    end
    send(noise_word(ACT_EXEC));
  endtask

  function automatic logic [15:0] pick_op();
    logic [15:0] op;
    op = 16'($urandom);
    case (op[15:12])
      OP_SYS: case ($urandom_range(2))
        0: op[7:0] = SYS_CLS;
        1: op[7:0] = SYS_RET;
        default: ;
      endcase
      OP_SER, OP_SNER: if ($urandom_range(3) != 0) op[3:0] = 4'h0;
      OP_ALU: if ($urandom_range(4) != 0) begin
        op[3:0] = 4'($urandom_range(8));
        if (op[3:0] == 4'h8) op[3:0] = ALU_SHL;
      end
      OP_KEY: case ($urandom_range(2))
        0: op[7:0] = KEY_SKP;
        1: op[7:0] = KEY_SKNP;
        default: ;
      endcase
      OP_MISC: case ($urandom_range(8))
        0: op[7:0] = FX_GETDT;
        1: op[7:0] = FX_SETDT;
        2: op[7:0] = FX_SETST;
        3: op[7:0] = FX_ADDI;
        4: op[7:0] = FX_FONT;
        5: op[7:0] = FX_BCD;
        6: op[7:0] = FX_STORE;
        7: op[7:0] = FX_LOAD;
        default: ;
      endcase
      default: ;
    endcase
    return op;
  endfunction

  initial begin
    in_word_t w;
    int sel;
    bit drained;
    mirror = new();
    idle_pct = 8;
    drained = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    w = noise_word(ACT_ROW);
    w.row_index = 5'd31;
    send(w);
    send(noise_word(ACT_TICK));
    w = noise_word(ACT_KEY);
    w.key_index = 4'hF;
    w.key_down = 1'b1;
    send(w);
    send(noise_word(3'd7));
    run_op(16'h6AFF, 1);
    run_op(16'h6B01, 1);
    run_op(16'h8AB4, 1);
    run_op(16'hFA29, 1);
    run_op(16'hDAB5, 1);
    w = noise_word(ACT_ROW);
    w.row_index = 5'd1;
    send(w);
    run_op(16'hDAB5, 1);
    run_op(16'h00E0, 1);

    for (int k = 0; k < 1830; k++) begin
      idle_pct = (k >= 600 && k < 1000) ? 0 : 8;
      if (k >= 1200 && !drained) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        while (mirror.expected_words.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
      end
      sel = $urandom_range(99);
      if (sel < 45) begin
        run_op(pick_op(), 1);
        k += 2;
      end else if (sel < 50) send(noise_word(ACT_EXEC));
      else if (sel < 62) send(noise_word(ACT_TICK));
      else if (sel < 70) send(noise_word(ACT_KEY));
      else if (sel < 82) send(noise_word(ACT_ROW));
      else if (sel < 92) send(noise_word(ACT_LOAD));
      else send(noise_word(3'($urandom_range(7, 5))));
    end

    in_valid <= 1'b0;
    while (mirror.expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("chip8_instruction_core_tb: done, clean");
    end else begin
      $display("chip8_instruction_core_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
